@@ rtl/core/bx3_pkg.sv @@
package bx3_pkg;

   localparam int MAX_ROW         = 64;
   localparam int MAX_PLANE       = 4096;
   localparam int MAX_PLANES      = 65536;
   localparam int SAMPLE_BITS     = 16;

   localparam int ROW_LEN_BITS    = 7;
   localparam int PLANE_SIZE_BITS = 13;
   localparam int VOLUME_BITS     = 29;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = VOLUME_BITS;

   localparam int X_BITS          = 6;
   localparam int Y_BITS          = 12;
   localparam int Z_BITS          = 16;
   localparam int NZ_BITS         = Z_BITS + 1;

   localparam int ROW_ADDR_BITS   = $clog2(MAX_ROW);
   localparam int PLANE_ADDR_BITS = $clog2(MAX_PLANE);

   localparam int DIV_STEPS       = VOLUME_BITS;
   localparam int STEP_BITS       = $clog2(DIV_STEPS);

   localparam int ROW_SUM_BITS    = SAMPLE_BITS + 2;
   localparam int SUM_BITS        = SAMPLE_BITS + 5;
   localparam int RECIP_BITS      = 23;
   localparam int RECIP_SHIFT     = 26;
   localparam int PROD_BITS       = SUM_BITS + RECIP_BITS;

   localparam logic [ROW_LEN_BITS-1:0]    ROW_LENGTH_RESET  = ROW_LEN_BITS'(16);
   localparam logic [PLANE_SIZE_BITS-1:0] PLANE_SIZE_RESET  = PLANE_SIZE_BITS'(256);
   localparam logic [VOLUME_BITS-1:0]     VOLUME_SIZE_RESET = VOLUME_BITS'(4096);
   localparam logic [ROW_LEN_BITS-1:0]    ROW_MIN           = ROW_LEN_BITS'(3);
   localparam logic [ROW_LEN_BITS-1:0]    ROW_MAX           = ROW_LEN_BITS'(MAX_ROW);
   localparam logic [PLANE_SIZE_BITS-1:0] PLANE_MIN         = PLANE_SIZE_BITS'(9);
   localparam logic [PLANE_SIZE_BITS-1:0] PLANE_MAX         = PLANE_SIZE_BITS'(MAX_PLANE);

   typedef logic signed [SAMPLE_BITS-1:0]  sample_type;
   typedef sample_type [2:0][2:0][2:0]     window_type;
   typedef logic signed [ROW_SUM_BITS-1:0] row_sum_type;
   typedef logic signed [SUM_BITS-1:0]     sum_type;
   typedef logic signed [PROD_BITS-1:0]    prod_type;

   localparam prod_type RECIP27    = prod_type'(2485513);
   localparam prod_type ROUND_BIAS = prod_type'(1) <<< (RECIP_SHIFT - 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_LENGTH  = 2'd0,
      CSR_PLANE_SIZE  = 2'd1,
      CSR_VOLUME_SIZE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [X_BITS-1:0] center_x;
      logic [Y_BITS-1:0] center_y;
      logic [Z_BITS-1:0] center_z;
      logic              last;
   } tag_type;

   typedef struct packed {
      logic                       run;
      logic                       restart;
      logic [ROW_ADDR_BITS-1:0]   row_wrap;
      logic [PLANE_ADDR_BITS-1:0] plane_wrap;
   } geom_type;

endpackage

@@ rtl/core/bx3_req_if.sv @@
interface bx3_req_if;
   logic                valid;
   logic                ready;
   bx3_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

@@ rtl/core/bx3_rsp_if.sv @@
interface bx3_rsp_if;
   logic                        valid;
   logic                        ready;
   bx3_pkg::sample_type         average;
   logic [bx3_pkg::X_BITS-1:0]  center_x;
   logic [bx3_pkg::Y_BITS-1:0]  center_y;
   logic [bx3_pkg::Z_BITS-1:0]  center_z;
   logic                        last;

   modport source (output valid, output average, output center_x, output center_y,
                   output center_z, output last, input ready);
   modport sink (input valid, input average, input center_x, input center_y,
                 input center_z, input last, output ready);
endinterface

@@ rtl/core/bx3_ram.sv @@
module bx3_ram #(
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wdata,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   // read old contents, then overwrite
   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff     <= mem_ff[addr];
         mem_ff[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/bx3_ctrl.sv @@
module bx3_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bx3_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bx3_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                accept,
   output bx3_pkg::geom_type                   geom,
   output logic                                emit,
   output bx3_pkg::tag_type                    tag
);

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_DIV_NY = 5'b00010,
      ST_DIV_NZ = 5'b00100,
      ST_MUL    = 5'b01000,
      ST_RUN    = 5'b10000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [bx3_pkg::ROW_LEN_BITS-1:0]    row_length_ff, row_length_in;
   logic [bx3_pkg::PLANE_SIZE_BITS-1:0] plane_size_ff, plane_size_in;
   logic [bx3_pkg::VOLUME_BITS-1:0]     volume_size_ff, volume_size_in;
   logic                                restart;

   logic [bx3_pkg::ROW_LEN_BITS-1:0]    nx_ff, nx_in;
   logic [bx3_pkg::Y_BITS-1:0]          ny_ff, ny_in;
   logic [bx3_pkg::NZ_BITS-1:0]         nz_ff, nz_in;
   logic [bx3_pkg::ROW_ADDR_BITS-1:0]   row_wrap_ff, row_wrap_in;
   logic [bx3_pkg::PLANE_ADDR_BITS-1:0] plane_wrap_ff, plane_wrap_in;

   logic [bx3_pkg::PLANE_SIZE_BITS-1:0] rem_ff, rem_in;
   logic [bx3_pkg::VOLUME_BITS-1:0]     quo_ff, quo_in;
   logic [bx3_pkg::PLANE_SIZE_BITS-1:0] dvsr_ff, dvsr_in;
   logic [bx3_pkg::STEP_BITS-1:0]       step_ff, step_in;

   logic [bx3_pkg::X_BITS-1:0]          pos_x_ff, pos_x_in;
   logic [bx3_pkg::Y_BITS-1:0]          pos_y_ff, pos_y_in;
   logic [bx3_pkg::Z_BITS-1:0]          pos_z_ff, pos_z_in;

   logic [bx3_pkg::ROW_LEN_BITS-1:0]    nx_c;
   logic [bx3_pkg::PLANE_SIZE_BITS-1:0] plane_c;
   logic [bx3_pkg::PLANE_SIZE_BITS:0]   trial;
   logic                                trial_ge;
   logic [bx3_pkg::PLANE_SIZE_BITS-1:0] rem_next;
   logic [bx3_pkg::VOLUME_BITS-1:0]     quo_next;
   logic [bx3_pkg::ROW_LEN_BITS+bx3_pkg::Y_BITS-1:0] pstride;
   logic [bx3_pkg::Y_BITS-1:0]          ny_c;
   logic [bx3_pkg::NZ_BITS-1:0]         nz_c;
   logic [bx3_pkg::ROW_LEN_BITS-1:0]    x_next;
   logic [bx3_pkg::Y_BITS:0]            y_next;
   logic [bx3_pkg::NZ_BITS-1:0]         z_next;

   // register writes
   always_comb begin
      restart        = 1'b0;
      row_length_in  = row_length_ff;
      plane_size_in  = plane_size_ff;
      volume_size_in = volume_size_ff;
      if (csr_we) begin
         unique case (bx3_pkg::csr_index_type'(csr_index))
            bx3_pkg::CSR_ROW_LENGTH: begin
               row_length_in = csr_wdata[bx3_pkg::ROW_LEN_BITS-1:0];
               restart       = 1'b1;
            end
            bx3_pkg::CSR_PLANE_SIZE: begin
               plane_size_in = csr_wdata[bx3_pkg::PLANE_SIZE_BITS-1:0];
               restart       = 1'b1;
            end
            bx3_pkg::CSR_VOLUME_SIZE: begin
               volume_size_in = csr_wdata;
               restart        = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (row_length_ff < bx3_pkg::ROW_MIN) begin
         nx_c = bx3_pkg::ROW_MIN;
      end else if (row_length_ff > bx3_pkg::ROW_MAX) begin
         nx_c = bx3_pkg::ROW_MAX;
      end else begin
         nx_c = row_length_ff;
      end
      if (plane_size_ff < bx3_pkg::PLANE_MIN) begin
         plane_c = bx3_pkg::PLANE_MIN;
      end else if (plane_size_ff > bx3_pkg::PLANE_MAX) begin
         plane_c = bx3_pkg::PLANE_MAX;
      end else begin
         plane_c = plane_size_ff;
      end
   end

   // one restoring division step
   always_comb begin
      trial    = {rem_ff, quo_ff[bx3_pkg::VOLUME_BITS-1]};
      trial_ge = trial >= {1'b0, dvsr_ff};
      rem_next = trial_ge ? bx3_pkg::PLANE_SIZE_BITS'(trial - {1'b0, dvsr_ff})
                          : trial[bx3_pkg::PLANE_SIZE_BITS-1:0];
      quo_next = {quo_ff[bx3_pkg::VOLUME_BITS-2:0], trial_ge};
      pstride  = nx_ff * ny_ff;
   end

   always_comb begin
      state_in      = state_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      nz_in         = nz_ff;
      row_wrap_in   = row_wrap_ff;
      plane_wrap_in = plane_wrap_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvsr_in       = dvsr_ff;
      step_in       = step_ff;
      unique case (state_ff)
         ST_LOAD: begin
            nx_in       = nx_c;
            row_wrap_in = bx3_pkg::ROW_ADDR_BITS'(nx_c - bx3_pkg::ROW_LEN_BITS'(2));
            quo_in      = bx3_pkg::VOLUME_BITS'(plane_c);
            dvsr_in     = bx3_pkg::PLANE_SIZE_BITS'(nx_c);
            rem_in      = '0;
            step_in     = '0;
            state_in    = ST_DIV_NY;
         end
         ST_DIV_NY: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            step_in = step_ff + bx3_pkg::STEP_BITS'(1);
            if (step_ff == bx3_pkg::STEP_BITS'(bx3_pkg::DIV_STEPS - 1)) begin
               ny_in    = quo_next[bx3_pkg::Y_BITS-1:0];
               quo_in   = volume_size_ff;
               dvsr_in  = plane_c;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV_NZ;
            end
         end
         ST_DIV_NZ: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            step_in = step_ff + bx3_pkg::STEP_BITS'(1);
            if (step_ff == bx3_pkg::STEP_BITS'(bx3_pkg::DIV_STEPS - 1)) begin
               if (quo_next > bx3_pkg::VOLUME_BITS'(bx3_pkg::MAX_PLANES)) begin
                  nz_in = bx3_pkg::NZ_BITS'(bx3_pkg::MAX_PLANES);
               end else begin
                  nz_in = quo_next[bx3_pkg::NZ_BITS-1:0];
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            plane_wrap_in = bx3_pkg::PLANE_ADDR_BITS'(pstride - $bits(pstride)'(2));
            state_in      = ST_RUN;
         end
         ST_RUN: ;
         default: state_in = ST_LOAD;
      endcase
      if (restart) begin
         state_in = ST_LOAD;
      end
   end

   // raster position
   always_comb begin
      ny_c     = (ny_ff == '0) ? bx3_pkg::Y_BITS'(1) : ny_ff;
      nz_c     = (nz_ff == '0) ? bx3_pkg::NZ_BITS'(1) : nz_ff;
      x_next   = {1'b0, pos_x_ff} + bx3_pkg::ROW_LEN_BITS'(1);
      y_next   = {1'b0, pos_y_ff} + (bx3_pkg::Y_BITS + 1)'(1);
      z_next   = {1'b0, pos_z_ff} + bx3_pkg::NZ_BITS'(1);
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (restart) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (accept) begin
         if (x_next >= nx_ff) begin
            pos_x_in = '0;
            if (y_next >= {1'b0, ny_c}) begin
               pos_y_in = '0;
               if (z_next >= nz_c) begin
                  pos_z_in = '0;
               end else begin
                  pos_z_in = z_next[bx3_pkg::Z_BITS-1:0];
               end
            end else begin
               pos_y_in = y_next[bx3_pkg::Y_BITS-1:0];
            end
         end else begin
            pos_x_in = x_next[bx3_pkg::X_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         row_length_ff  <= bx3_pkg::ROW_LENGTH_RESET;
         plane_size_ff  <= bx3_pkg::PLANE_SIZE_RESET;
         volume_size_ff <= bx3_pkg::VOLUME_SIZE_RESET;
         nx_ff          <= bx3_pkg::ROW_LENGTH_RESET;
         ny_ff          <= bx3_pkg::Y_BITS'(16);
         nz_ff          <= bx3_pkg::NZ_BITS'(16);
         row_wrap_ff    <= '0;
         plane_wrap_ff  <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         pos_z_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         row_length_ff  <= row_length_in;
         plane_size_ff  <= plane_size_in;
         volume_size_ff <= volume_size_in;
         nx_ff          <= nx_in;
         ny_ff          <= ny_in;
         nz_ff          <= nz_in;
         row_wrap_ff    <= row_wrap_in;
         plane_wrap_ff  <= plane_wrap_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         pos_z_ff       <= pos_z_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      step_ff <= step_in;
   end

   always_comb begin
      geom.run        = (state_ff == ST_RUN);
      geom.restart    = restart;
      geom.row_wrap   = row_wrap_ff;
      geom.plane_wrap = plane_wrap_ff;

      emit = (pos_x_ff >= bx3_pkg::X_BITS'(2)) && (pos_y_ff >= bx3_pkg::Y_BITS'(2)) &&
             (pos_z_ff >= bx3_pkg::Z_BITS'(2)) && ({1'b0, pos_x_ff} < nx_ff) &&
             (pos_y_ff < ny_ff) && ({1'b0, pos_z_ff} < nz_ff);

      tag.center_x = pos_x_ff - bx3_pkg::X_BITS'(1);
      tag.center_y = pos_y_ff - bx3_pkg::Y_BITS'(1);
      tag.center_z = pos_z_ff - bx3_pkg::Z_BITS'(1);
      tag.last     = emit && ({1'b0, pos_x_ff} == nx_ff - bx3_pkg::ROW_LEN_BITS'(1)) &&
                     (pos_y_ff == ny_ff - bx3_pkg::Y_BITS'(1)) &&
                     ({1'b0, pos_z_ff} == nz_ff - bx3_pkg::NZ_BITS'(1));
   end

   assert property (@(posedge clock) disable iff (reset) restart |=> !geom.run)
      else $error("sequencer still running after a register write");

   assert property (@(posedge clock) disable iff (reset)
      geom.run |-> ({1'b0, pos_x_ff} < nx_ff))
      else $error("x position beyond row length");

   assert property (@(posedge clock) disable iff (reset) accept |-> geom.run)
      else $error("transfer taken while extents are being derived");

endmodule

@@ rtl/core/bx3_window.sv @@
module bx3_window (
   input  logic                 clock,
   input  logic                 reset,
   input  bx3_pkg::geom_type    geom,
   input  logic                 accept,
   input  bx3_pkg::sample_type  sample,
   output bx3_pkg::window_type  window
);

   logic [bx3_pkg::ROW_ADDR_BITS-1:0]   row_ptr_ff, row_ptr_in;
   logic [bx3_pkg::PLANE_ADDR_BITS-1:0] plane_ptr_ff, plane_ptr_in;
   bx3_pkg::sample_type                 sample_ff;
   bx3_pkg::sample_type                 head [3][3];
   bx3_pkg::sample_type                 tail1_ff [3][3];
   bx3_pkg::sample_type                 tail2_ff [3][3];

   // each delay line is fed from a register, so it runs one entry short
   always_comb begin
      row_ptr_in   = row_ptr_ff;
      plane_ptr_in = plane_ptr_ff;
      if (geom.restart) begin
         row_ptr_in   = '0;
         plane_ptr_in = '0;
      end else if (accept) begin
         row_ptr_in   = (row_ptr_ff >= geom.row_wrap) ? '0
                        : row_ptr_ff + bx3_pkg::ROW_ADDR_BITS'(1);
         plane_ptr_in = (plane_ptr_ff >= geom.plane_wrap) ? '0
                        : plane_ptr_ff + bx3_pkg::PLANE_ADDR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ptr_ff   <= '0;
         plane_ptr_ff <= '0;
      end else begin
         row_ptr_ff   <= row_ptr_in;
         plane_ptr_ff <= plane_ptr_in;
      end
   end

   assign head[0][0] = sample_ff;

   for (genvar dz = 0; dz < 2; dz++) begin : g_plane_line
      bx3_ram #(
         .ADDR_BITS (bx3_pkg::PLANE_ADDR_BITS),
         .DATA_BITS (bx3_pkg::SAMPLE_BITS)
      ) u_plane_ram (
         .clock (clock),
         .en    (accept),
         .addr  (plane_ptr_ff),
         .wdata (head[dz][0]),
         .rdata (head[dz+1][0])
      );
   end

   for (genvar dz = 0; dz < 3; dz++) begin : g_row_plane
      for (genvar dy = 0; dy < 2; dy++) begin : g_row_line
         bx3_ram #(
            .ADDR_BITS (bx3_pkg::ROW_ADDR_BITS),
            .DATA_BITS (bx3_pkg::SAMPLE_BITS)
         ) u_row_ram (
            .clock (clock),
            .en    (accept),
            .addr  (row_ptr_ff),
            .wdata (head[dz][dy]),
            .rdata (head[dz][dy+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= sample;
         for (int dz = 0; dz < 3; dz++) begin
            for (int dy = 0; dy < 3; dy++) begin
               tail1_ff[dz][dy] <= head[dz][dy];
               tail2_ff[dz][dy] <= tail1_ff[dz][dy];
            end
         end
      end
   end

   always_comb begin
      for (int dz = 0; dz < 3; dz++) begin
         for (int dy = 0; dy < 3; dy++) begin
            window[dz][dy][0] = head[dz][dy];
            window[dz][dy][1] = tail1_ff[dz][dy];
            window[dz][dy][2] = tail2_ff[dz][dy];
         end
      end
   end

endmodule

@@ rtl/core/bx3_mean.sv @@
module bx3_mean (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bx3_pkg::tag_type     tag,
   input  bx3_pkg::window_type  window,
   output logic                 ready,
   bx3_rsp_if.source            rsp_bus
);

   logic                 v0_ff, v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic                 en1, en2, en3, en4;
   bx3_pkg::tag_type     tag0_ff, tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   bx3_pkg::row_sum_type rsum_ff [3][3];
   bx3_pkg::row_sum_type rsum_in [3][3];
   bx3_pkg::sum_type     total_ff, total_in;
   bx3_pkg::sum_type     plane_sum;
   bx3_pkg::prod_type    prod_ff, prod_in;
   bx3_pkg::prod_type    rounded;
   bx3_pkg::sample_type  average_ff, average_in;

   always_comb begin
      en4   = !out_valid_ff || rsp_bus.ready;
      en3   = !v3_ff || en4;
      en2   = !v2_ff || en3;
      en1   = !v1_ff || en2;
      ready = !v0_ff || en1;
   end

   always_comb begin
      for (int dz = 0; dz < 3; dz++) begin
         for (int dy = 0; dy < 3; dy++) begin
            rsum_in[dz][dy] = bx3_pkg::row_sum_type'(window[dz][dy][0]) +
                              bx3_pkg::row_sum_type'(window[dz][dy][1]) +
                              bx3_pkg::row_sum_type'(window[dz][dy][2]);
         end
      end
      total_in = '0;
      for (int dz = 0; dz < 3; dz++) begin
         plane_sum = bx3_pkg::sum_type'(rsum_ff[dz][0]) +
                     bx3_pkg::sum_type'(rsum_ff[dz][1]) +
                     bx3_pkg::sum_type'(rsum_ff[dz][2]);
         total_in  = total_in + plane_sum;
      end
      prod_in    = bx3_pkg::prod_type'(total_ff) * bx3_pkg::RECIP27;
      rounded    = prod_ff + bx3_pkg::ROUND_BIAS;
      average_in = rounded[bx3_pkg::RECIP_SHIFT +: bx3_pkg::SAMPLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready) begin
            v0_ff <= load;
         end
         if (en1) begin
            v1_ff <= v0_ff;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            out_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         tag0_ff <= tag;
      end
      if (en1) begin
         rsum_ff <= rsum_in;
         tag1_ff <= tag0_ff;
      end
      if (en2) begin
         total_ff <= total_in;
         tag2_ff  <= tag1_ff;
      end
      if (en3) begin
         prod_ff <= prod_in;
         tag3_ff <= tag2_ff;
      end
      if (en4) begin
         average_ff <= average_in;
         tag4_ff    <= tag3_ff;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.average  = average_ff;
   assign rsp_bus.center_x = tag4_ff.center_x;
   assign rsp_bus.center_y = tag4_ff.center_y;
   assign rsp_bus.center_z = tag4_ff.center_z;
   assign rsp_bus.last     = tag4_ff.last;

endmodule

@@ rtl/core/box_average_3d_stencil_core.sv @@
// channel   direction  handshake        payload
// req_bus   in         valid / ready    sample (signed Q8.8)
// rsp_bus   out        valid / ready    average, center_x, center_y, center_z, last
// csr_*     in         csr_we           csr_index, csr_wdata (no read-back)
//
// One sample per cycle while req_bus.ready is high; the five register stages of the
// mean pipeline carry each result after the transfer completing its 3x3x3 window.
// After reset and after every write to a defined register, req_bus.ready stays low
// while one serial divider derives the row and plane counts (29 steps each).
// A stalled rsp_bus fills the five-stage mean pipeline, then holds req_bus.ready low.
// Reset clears position, pointers and pipeline valids; history needs no clearing.
module box_average_3d_stencil_core (
   input  logic                               clock,
   input  logic                               reset,
   bx3_req_if.sink                            req_bus,
   bx3_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [bx3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bx3_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   bx3_pkg::geom_type    geom;
   bx3_pkg::tag_type     tag;
   bx3_pkg::window_type  window;
   logic                 emit;
   logic                 mean_ready;
   logic                 req_ready;
   logic                 accept;

   assign req_ready     = geom.run && mean_ready;
   assign accept        = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   bx3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .geom      (geom),
      .emit      (emit),
      .tag       (tag)
   );

   bx3_window u_window (
      .clock  (clock),
      .reset  (reset),
      .geom   (geom),
      .accept (accept),
      .sample (req_bus.sample),
      .window (window)
   );

   bx3_mean u_mean (
      .clock   (clock),
      .reset   (reset),
      .load    (accept && emit),
      .tag     (tag),
      .window  (window),
      .ready   (mean_ready),
      .rsp_bus (rsp_bus)
   );

endmodule
